FILE: rtl/core/cwg_pkg.sv
`timescale 1ns / 1ps
// cwg_pkg: shared types, codes and field widths for the category word grouper
// depends on nothing; used by cwg_ctrl, category_word_grouper and both checkers
package cwg_pkg;

    // fixed field widths of the item and config ports
    localparam int REQ_W       = 2;
    localparam int CAT_FIELD_W = 8;
    localparam int POS_W       = 12;
    localparam int WORD_ID_W   = 12;
    localparam int LEN_W       = 13;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 9;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CATEGORY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POSITION = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT    = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]       req_type;
        logic [CAT_FIELD_W-1:0] category;
        logic [POS_W-1:0]       position;
    } t_in_item;

    typedef struct packed {
        logic [WORD_ID_W-1:0] word_id;
        logic [LEN_W-1:0]     list_length;
        logic [STATUS_W-1:0]  status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LD0,
        S_LD1,
        S_BLD_RD,
        S_BLD_WR,
        S_SC0,
        S_SC1,
        S_SC2,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_CLR,
        S_RESP
    } t_state;

    // operand pairs for the shared add/compare unit
    typedef enum logic [2:0] {
        ALU_CAT,
        ALU_INC_SIZE,
        ALU_RUN,
        ALU_INC_FILL,
        ALU_POS,
        ALU_SLOT
    } t_alu_sel;

    // which result an item finishes with
    typedef enum logic [3:0] {
        RES_LD_OK,
        RES_LD_BADCAT,
        RES_LD_FULL,
        RES_TOTAL,
        RES_CLEAR,
        RES_RD_BADCAT,
        RES_NOTBUILT,
        RES_BADPOS,
        RES_RD_OK
    } t_res_sel;

    // sequencer to datapath
    typedef struct packed {
        logic     idle;
        logic     idx_clr;
        logic     idx_inc;
        logic     run_clr;
        logic     run_add;
        t_alu_sel alu_sel;
        logic     size_rd;
        logic     size_at_idx;
        logic     size_wr;
        logic     cat_wr;
        logic     cat_rd;
        logic     start_rd;
        logic     pfx_wr;
        logic     fill_rd;
        logic     fill_wr;
        logic     group_rd;
        logic     group_wr;
        logic     total_inc;
        logic     total_clr;
        logic     built_set;
        logic     built_clr;
        logic     res_we;
        t_res_sel res_sel;
        logic     out_load;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic             acc;
        logic [REQ_W-1:0] req;
        logic             lt;
        logic             cat_ok;
        logic             full;
        logic             built;
        logic             last_cat;
        logic             last_word;
        logic             total_zero;
        logic             out_free;
    } t_sts;

endpackage

FILE: rtl/core/cwg_alu.sv
`timescale 1ns / 1ps
// cwg_alu: adder and less-than compare shared by the steps of the sequencer
// depends on nothing
module cwg_alu #(
    parameter int W = 13
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_sum,
    output logic         o_lt
);

    // one add and one unsigned compare on the same operand pair
    assign o_sum = i_a + i_b;
    assign o_lt  = (i_a < i_b);

endmodule

FILE: rtl/core/cwg_ctrl.sv
`timescale 1ns / 1ps
// cwg_ctrl: sequencer for load, build, read and clear requests
// depends on cwg_pkg (state, control and status types)
module cwg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cwg_pkg::t_sts i_sts,
    output cwg_pkg::t_ctl o_ctl
);
    import cwg_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register, reset starts the size clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.last_cat) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.acc) begin
                    case (i_sts.req)
                        REQ_LOAD:  n_state = S_LD0;
                        REQ_BUILD: n_state = S_BLD_RD;
                        REQ_READ:  n_state = S_RD0;
                        REQ_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LD0: begin
                if (!i_sts.cat_ok || i_sts.full) n_state = S_RESP;
                else                             n_state = S_LD1;
            end
            S_LD1:    n_state = S_RESP;
            S_BLD_RD: n_state = S_BLD_WR;
            S_BLD_WR: begin
                if (i_sts.last_cat) begin
                    n_state = i_sts.total_zero ? S_RESP : S_SC0;
                end else begin
                    n_state = S_BLD_RD;
                end
            end
            S_SC0: n_state = S_SC1;
            S_SC1: n_state = S_SC2;
            S_SC2: begin
                n_state = i_sts.last_word ? S_RESP : S_SC0;
            end
            S_RD0: begin
                if (!i_sts.cat_ok || !i_sts.built) n_state = S_RESP;
                else                               n_state = S_RD1;
            end
            S_RD1: n_state = i_sts.lt ? S_RD2 : S_RESP;
            S_RD2: n_state = S_RD3;
            S_RD3: n_state = S_RESP;
            S_CLR: begin
                if (i_sts.last_cat) n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctl = '0;
        case (r_state)
            S_INIT: begin
                o_ctl.size_wr     = 1'b1;
                o_ctl.size_at_idx = 1'b1;
                o_ctl.idx_inc     = 1'b1;
                o_ctl.idx_clr     = i_sts.last_cat;
            end
            S_IDLE: begin
                o_ctl.idle    = 1'b1;
                o_ctl.idx_clr = 1'b1;
                o_ctl.run_clr = 1'b1;
            end
            S_LD0: begin
                o_ctl.alu_sel = ALU_CAT;
                if (!i_sts.cat_ok) begin
                    o_ctl.res_we  = 1'b1;
                    o_ctl.res_sel = RES_LD_BADCAT;
                end else if (i_sts.full) begin
                    o_ctl.res_we  = 1'b1;
                    o_ctl.res_sel = RES_LD_FULL;
                end else begin
                    o_ctl.cat_wr  = 1'b1;
                    o_ctl.size_rd = 1'b1;
                end
            end
            S_LD1: begin
                o_ctl.alu_sel   = ALU_INC_SIZE;
                o_ctl.size_wr   = 1'b1;
                o_ctl.total_inc = 1'b1;
                o_ctl.built_clr = 1'b1;
                o_ctl.res_we    = 1'b1;
                o_ctl.res_sel   = RES_LD_OK;
            end
            S_BLD_RD: begin
                o_ctl.size_rd     = 1'b1;
                o_ctl.size_at_idx = 1'b1;
            end
            S_BLD_WR: begin
                o_ctl.alu_sel = ALU_RUN;
                o_ctl.pfx_wr  = 1'b1;
                o_ctl.run_add = 1'b1;
                o_ctl.idx_inc = 1'b1;
                if (i_sts.last_cat) begin
                    o_ctl.idx_clr = 1'b1;
                    if (i_sts.total_zero) begin
                        o_ctl.built_set = 1'b1;
                        o_ctl.res_we    = 1'b1;
                        o_ctl.res_sel   = RES_TOTAL;
                    end
                end
            end
            S_SC0: begin
                o_ctl.cat_rd = 1'b1;
            end
            S_SC1: begin
                o_ctl.fill_rd = 1'b1;
            end
            S_SC2: begin
                o_ctl.alu_sel  = ALU_INC_FILL;
                o_ctl.fill_wr  = 1'b1;
                o_ctl.group_wr = 1'b1;
                o_ctl.idx_inc  = 1'b1;
                if (i_sts.last_word) begin
                    o_ctl.built_set = 1'b1;
                    o_ctl.res_we    = 1'b1;
                    o_ctl.res_sel   = RES_TOTAL;
                end
            end
            S_RD0: begin
                o_ctl.alu_sel = ALU_CAT;
                if (!i_sts.cat_ok) begin
                    o_ctl.res_we  = 1'b1;
                    o_ctl.res_sel = RES_RD_BADCAT;
                end else if (!i_sts.built) begin
                    o_ctl.res_we  = 1'b1;
                    o_ctl.res_sel = RES_NOTBUILT;
                end else begin
                    o_ctl.size_rd  = 1'b1;
                    o_ctl.start_rd = 1'b1;
                end
            end
            S_RD1: begin
                o_ctl.alu_sel = ALU_POS;
                if (!i_sts.lt) begin
                    o_ctl.res_we  = 1'b1;
                    o_ctl.res_sel = RES_BADPOS;
                end
            end
            S_RD2: begin
                o_ctl.alu_sel  = ALU_SLOT;
                o_ctl.group_rd = 1'b1;
            end
            S_RD3: begin
                o_ctl.res_we  = 1'b1;
                o_ctl.res_sel = RES_RD_OK;
            end
            S_CLR: begin
                o_ctl.size_wr     = 1'b1;
                o_ctl.size_at_idx = 1'b1;
                o_ctl.idx_inc     = 1'b1;
                if (i_sts.last_cat) begin
                    o_ctl.total_clr = 1'b1;
                    o_ctl.built_clr = 1'b1;
                    o_ctl.res_we    = 1'b1;
                    o_ctl.res_sel   = RES_CLEAR;
                end
            end
            S_RESP: begin
                o_ctl.out_load = i_sts.out_free;
            end
            default: o_ctl = '0;
        endcase
    end

endmodule

FILE: rtl/core/category_word_grouper.sv
`timescale 1ns / 1ps
// category_word_grouper: stable counting-sort grouping of word indices by category
// depends on cwg_pkg, cwg_alu (shared add/compare) and cwg_ctrl (sequencer)
//
// channel   dir  handshake            payload
// item in   in   i_valid / o_stall    i_item  (req_type, category, position)
// item out  out  o_valid / i_stall    o_item  (word_id, list_length, status)
// config    in   i_cfg_we             i_cfg_wdata (category_count)
//
// after an item is taken: load checks category and space, then writes the size; read
//   checks category and built flag, then position, then reads the grouped store; clear
//   sweeps every size entry; build sums sizes into list starts, then scatters each
//   word; each item ends by loading the output register; a failed check ends it early
// all steps share one adder/compare unit and single-port registered memory reads
// reset starts a clearing pass over all MAX_CATEGORIES entries of the size memory
// o_stall is low only when the sequencer is idle; a finished item waits in the
//   output register while the next item is accepted, and a stalled result holds
//   the sequencer in its last step
module category_word_grouper #(
    parameter int MAX_WORDS      = 4096,
    parameter int MAX_CATEGORIES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  cwg_pkg::t_in_item                i_item,
    output logic                             o_valid,
    input  logic                             i_stall,
    output cwg_pkg::t_out_item               o_item,
    input  logic                             i_cfg_we,
    input  logic [cwg_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import cwg_pkg::*;

    localparam int WORD_W = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int CAT_W  = (MAX_CATEGORIES > 2) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int IDX_W  = (CAT_W > WORD_W) ? CAT_W : WORD_W;
    localparam int OP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    t_ctl ctl;
    t_sts sts;

    // control and datapath registers
    logic [CFG_W-1:0] r_cfg;
    t_in_item         r_in;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [CNT_W-1:0] r_run;
    logic [CNT_W-1:0] r_word_total;
    logic [CNT_W-1:0] n_word_total;
    logic             r_built;
    t_out_item        r_res;
    t_out_item        n_res;
    t_out_item        r_out;
    logic             r_out_valid;

    // memory read registers
    logic [CAT_W-1:0]  r_cat_q;
    logic [CNT_W-1:0]  r_size_q;
    logic [CNT_W-1:0]  r_start_q;
    logic [CNT_W-1:0]  r_fill_q;
    logic [WORD_W-1:0] r_group_q;

    // memories
    logic [CAT_W-1:0]  m_cat   [MAX_WORDS];
    logic [CNT_W-1:0]  m_size  [MAX_CATEGORIES];
    logic [CNT_W-1:0]  m_start [MAX_CATEGORIES];
    logic [CNT_W-1:0]  m_fill  [MAX_CATEGORIES];
    logic [WORD_W-1:0] m_group [MAX_WORDS];

    logic [OP_W-1:0]  alu_a;
    logic [OP_W-1:0]  alu_b;
    logic [OP_W-1:0]  alu_sum;
    logic             alu_lt;
    logic [CAT_W-1:0] cat_idx;
    logic [CAT_W-1:0] sweep_idx;
    logic [CAT_W-1:0] size_addr;
    logic             accept;
    logic             out_free;

    cwg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    cwg_alu #(
        .W (OP_W)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    // handshake
    assign accept   = i_valid && ctl.idle;
    assign o_stall  = !ctl.idle;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    assign cat_idx   = CAT_W'(r_in.category);
    assign sweep_idx = CAT_W'(r_idx);
    assign size_addr = ctl.size_at_idx ? sweep_idx : cat_idx;

    // status back to the sequencer
    always_comb begin
        sts            = '0;
        sts.acc        = accept;
        sts.req        = i_item.req_type;
        sts.lt         = alu_lt;
        sts.cat_ok     = alu_lt && (32'(r_in.category) < MAX_CATEGORIES);
        sts.full       = (r_word_total == CNT_W'(MAX_WORDS));
        sts.built      = r_built;
        sts.last_cat   = (r_idx == IDX_W'(MAX_CATEGORIES - 1));
        sts.last_word  = (CNT_W'(r_idx) == (r_word_total - CNT_W'(1)));
        sts.total_zero = (r_word_total == '0);
        sts.out_free   = out_free;
    end

    // operand select for the shared unit
    always_comb begin
        case (ctl.alu_sel)
            ALU_CAT: begin
                alu_a = OP_W'(r_in.category);
                alu_b = OP_W'(r_cfg);
            end
            ALU_INC_SIZE: begin
                alu_a = OP_W'(r_size_q);
                alu_b = OP_W'(1);
            end
            ALU_RUN: begin
                alu_a = OP_W'(r_run);
                alu_b = OP_W'(r_size_q);
            end
            ALU_INC_FILL: begin
                alu_a = OP_W'(r_fill_q);
                alu_b = OP_W'(1);
            end
            ALU_POS: begin
                alu_a = OP_W'(r_in.position);
                alu_b = OP_W'(r_size_q);
            end
            ALU_SLOT: begin
                alu_a = OP_W'(r_start_q);
                alu_b = OP_W'(r_in.position);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // captured request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    // sweep and word counter
    always_comb begin
        n_idx = r_idx;
        if (ctl.idx_clr)      n_idx = '0;
        else if (ctl.idx_inc) n_idx = r_idx + IDX_W'(1);
    end

    // word total
    always_comb begin
        n_word_total = r_word_total;
        if (ctl.total_clr)      n_word_total = '0;
        else if (ctl.total_inc) n_word_total = r_word_total + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_word_total <= '0;
            r_built      <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_word_total <= n_word_total;
            if (ctl.built_set)      r_built <= 1'b1;
            else if (ctl.built_clr) r_built <= 1'b0;
        end
    end

    // prefix sum running offset
    always_ff @(posedge i_clk) begin
        if (ctl.run_clr) begin
            r_run <= '0;
        end else if (ctl.run_add) begin
            r_run <= CNT_W'(alu_sum);
        end
    end

    // category of each loaded word
    always_ff @(posedge i_clk) begin
        if (ctl.cat_wr) begin
            m_cat[WORD_W'(r_word_total)] <= cat_idx;
        end
        if (ctl.cat_rd) begin
            r_cat_q <= m_cat[WORD_W'(r_idx)];
        end
    end

    // per-category word counts, kept up to date on every load
    always_ff @(posedge i_clk) begin
        if (ctl.size_wr) begin
            m_size[size_addr] <= ctl.size_at_idx ? '0 : CNT_W'(alu_sum);
        end
        if (ctl.size_rd) begin
            r_size_q <= m_size[size_addr];
        end
    end

    // list start offsets
    always_ff @(posedge i_clk) begin
        if (ctl.pfx_wr) begin
            m_start[sweep_idx] <= r_run;
        end
        if (ctl.start_rd) begin
            r_start_q <= m_start[cat_idx];
        end
    end

    // next free slot of each list during the scatter walk
    always_ff @(posedge i_clk) begin
        if (ctl.pfx_wr) begin
            m_fill[sweep_idx] <= r_run;
        end else if (ctl.fill_wr) begin
            m_fill[r_cat_q] <= CNT_W'(alu_sum);
        end
        if (ctl.fill_rd) begin
            r_fill_q <= m_fill[r_cat_q];
        end
    end

    // grouped word store
    always_ff @(posedge i_clk) begin
        if (ctl.group_wr) begin
            m_group[WORD_W'(r_fill_q)] <= WORD_W'(r_idx);
        end
        if (ctl.group_rd) begin
            r_group_q <= m_group[WORD_W'(alu_sum)];
        end
    end

    // result assembly
    always_comb begin
        n_res = '0;
        case (ctl.res_sel)
            RES_LD_OK: begin
                n_res.word_id     = WORD_ID_W'(r_word_total);
                n_res.list_length = LEN_W'(r_word_total + CNT_W'(1));
                n_res.status      = ST_OK;
            end
            RES_LD_BADCAT: begin
                n_res.list_length = LEN_W'(r_word_total);
                n_res.status      = ST_BAD_CATEGORY;
            end
            RES_LD_FULL: begin
                n_res.list_length = LEN_W'(r_word_total);
                n_res.status      = ST_FULL;
            end
            RES_TOTAL: begin
                n_res.list_length = LEN_W'(r_word_total);
                n_res.status      = ST_OK;
            end
            RES_CLEAR: begin
                n_res.status = ST_OK;
            end
            RES_RD_BADCAT: begin
                n_res.status = ST_BAD_CATEGORY;
            end
            RES_NOTBUILT: begin
                n_res.status = ST_NOT_BUILT;
            end
            RES_BADPOS: begin
                n_res.list_length = LEN_W'(r_size_q);
                n_res.status      = ST_BAD_POSITION;
            end
            RES_RD_OK: begin
                n_res.word_id     = WORD_ID_W'(r_group_q);
                n_res.list_length = LEN_W'(r_size_q);
                n_res.status      = ST_OK;
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.res_we) begin
            r_res <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out <= r_res;
        end
    end

endmodule

FILE: rtl/core/cwg_checker.sv
`timescale 1ns / 1ps
// cwg_port_checks: port-level checks on the category word grouper over time
// depends on cwg_pkg; bound to category_word_grouper below
module cwg_port_checks (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input cwg_pkg::t_out_item        o_item
);
    import cwg_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result item changed while stalled");

    // reset leaves the block busy with its clearing pass and no result shown
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("block not busy or result shown after reset");

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block ready right after accepting an item");

    // every error result carries a zero word index
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.status != ST_OK) |-> (o_item.word_id == '0))
        else $error("error result with nonzero word index");

    // a read that finds no valid build reports an empty list
    a_notbuilt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.status == ST_NOT_BUILT) |-> (o_item.list_length == '0))
        else $error("not-built result with nonzero length");

endmodule

bind category_word_grouper cwg_port_checks u_cwg_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_item      (o_item)
);

FILE: tb/cwg_checker.sv
`timescale 1ns / 1ps
// cwg_checker: predicts every result of the category word grouper and compares it
// depends on cwg_pkg; watches the item, result and register channels beside the block
module cwg_checker #(
    parameter int MAX_WORDS      = 4096,
    parameter int MAX_CATEGORIES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  cwg_pkg::t_in_item          i_in_item,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  cwg_pkg::t_out_item         i_out_item,
    input  logic                       i_cfg_we,
    input  logic [cwg_pkg::CFG_W-1:0]  i_cfg_wdata,
    output int                         o_pending,
    output int                         o_errors,
    output int                         o_checked
);
    import cwg_pkg::*;

    // shadow of the block's state
    logic [CFG_W-1:0]       cat_limit;
    logic [CAT_FIELD_W-1:0] word_cat   [MAX_WORDS];
    logic [LEN_W-1:0]       list_size  [MAX_CATEGORIES];
    logic [LEN_W-1:0]       list_start [MAX_CATEGORIES];
    logic [LEN_W-1:0]       fill_cnt   [MAX_CATEGORIES];
    logic [WORD_ID_W-1:0]   grouped    [MAX_WORDS];
    logic [LEN_W-1:0]       word_total;
    logic                   built;

    // results still owed by the block, oldest first
    t_out_item owed_results[$];

    task automatic report_mismatch(input string msg);
        if (o_errors < 40)
            $display("%0t ns  mismatch: %s", $time, msg);
        o_errors++;
    endtask

    // sample at the falling edge: a handshake seen here completes at the next rising edge
    always @(negedge i_clk) begin : track
        t_out_item want;
        int        act;
        int        run;
        int        cat;
        if (!i_rst_n) begin
            cat_limit  = CFG_RESET;
            word_total = '0;
            built      = 1'b0;
            o_errors   = 0;
            o_checked  = 0;
            for (int c = 0; c < MAX_CATEGORIES; c++)
                list_size[c] = '0;
            owed_results.delete();
        end else begin
            if (i_cfg_we)
                cat_limit = i_cfg_wdata;

            // predict the result of an accepted item
            if (i_in_valid && !i_in_stall) begin
                act  = (cat_limit > MAX_CATEGORIES) ? MAX_CATEGORIES : int'(cat_limit);
                want = '0;
                case (i_in_item.req_type)
                    REQ_LOAD: begin
                        if (i_in_item.category >= act) begin
                            want.status = ST_BAD_CATEGORY;
                        end else if (word_total >= MAX_WORDS) begin
                            want.status = ST_FULL;
                        end else begin
                            word_cat[word_total] = i_in_item.category;
                            want.word_id = word_total[WORD_ID_W-1:0];
                            word_total++;
                            built = 1'b0;
                        end
                        want.list_length = word_total;
                    end
                    REQ_BUILD: begin
                        // count, prefix sum, then a stable scatter in arrival order
                        for (int c = 0; c < MAX_CATEGORIES; c++) begin
                            list_size[c] = '0;
                            fill_cnt[c]  = '0;
                        end
                        for (int w = 0; w < word_total; w++)
                            list_size[word_cat[w]]++;
                        run = 0;
                        for (int c = 0; c < MAX_CATEGORIES; c++) begin
                            list_start[c] = run[LEN_W-1:0];
                            run += list_size[c];
                        end
                        for (int w = 0; w < word_total; w++) begin
                            cat = word_cat[w];
                            grouped[list_start[cat] + fill_cnt[cat]] = w[WORD_ID_W-1:0];
                            fill_cnt[cat]++;
                        end
                        built = 1'b1;
                        want.list_length = word_total;
                    end
                    REQ_READ: begin
                        cat = i_in_item.category;
                        if (cat >= act) begin
                            want.status = ST_BAD_CATEGORY;
                        end else if (!built) begin
                            want.status = ST_NOT_BUILT;
                        end else begin
                            want.list_length = list_size[cat];
                            if (i_in_item.position >= list_size[cat])
                                want.status = ST_BAD_POSITION;
                            else
                                want.word_id = grouped[list_start[cat] + i_in_item.position];
                        end
                    end
                    default: begin
                        word_total = '0;
                        built      = 1'b0;
                        for (int c = 0; c < MAX_CATEGORIES; c++)
                            list_size[c] = '0;
                    end
                endcase
                owed_results.push_back(want);
            end

            // compare an accepted result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: word %0d length %0d status %0d",
                                              i_out_item.word_id, i_out_item.list_length,
                                              i_out_item.status));
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_item.word_id !== want.word_id)
                        report_mismatch($sformatf("result %0d word_id %0d, expected %0d",
                                                  o_checked, i_out_item.word_id, want.word_id));
                    if (i_out_item.list_length !== want.list_length)
                        report_mismatch($sformatf("result %0d list_length %0d, expected %0d",
                                                  o_checked, i_out_item.list_length,
                                                  want.list_length));
                    if (i_out_item.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  o_checked, i_out_item.status, want.status));
                end
                o_checked++;
            end
        end
        o_pending = owed_results.size();
    end

endmodule

FILE: tb/tb_category_word_grouper.sv
`timescale 1ns / 1ps
// tb_category_word_grouper: stimulus and verdict for the category word grouper
// depends on cwg_pkg, category_word_grouper and cwg_checker
module tb_category_word_grouper;
    import cwg_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int MAX_C       = 256;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 350;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_in_item         i_item;
    logic             o_valid;
    logic             i_stall;
    t_out_item        o_item;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    int pending;
    int errors;
    int checked;

    // idling mix and count of receiver hold-off requests
    int send_idle_pct;
    int recv_stall_pct;
    int hold_reqs;

    // what the stimulus believes is loaded (to aim reads and time clears) and what it sent
    int cfg_now;
    int loaded_per_cat [MAX_C];
    int loaded_total;
    int sent_by_req [4];
    int cfg_writes;

    category_word_grouper #(
        .MAX_WORDS      (MAX_W),
        .MAX_CATEGORIES (MAX_C)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    cwg_checker #(
        .MAX_WORDS      (MAX_W),
        .MAX_CATEGORIES (MAX_C)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_item   (i_item),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_item  (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial begin : receiver
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_served && hold_left == 0) begin
                hold_served = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // offer one item and return at the edge that takes it
    task automatic send(input logic [REQ_W-1:0] req, input int cat, input int pos);
        t_in_item it;
        int       act;
        it.req_type = req;
        it.category = cat[CAT_FIELD_W-1:0];
        it.position = pos[POS_W-1:0];
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(negedge i_clk);
        while (o_stall)
            @(negedge i_clk);
        @(posedge i_clk);
        sent_by_req[req]++;
        act = (cfg_now > MAX_C) ? MAX_C : cfg_now;
        if (req == REQ_LOAD && it.category < act && loaded_total < MAX_W) begin
            loaded_per_cat[it.category]++;
            loaded_total++;
        end else if (req == REQ_CLEAR) begin
            loaded_total = 0;
            foreach (loaded_per_cat[c])
                loaded_per_cat[c] = 0;
        end
    endtask

    // stop offering until every result is back and the block is idle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        while (o_stall)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input int value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = value;
        cfg_writes++;
    endtask

    function automatic int pick_cfg();
        case ($urandom_range(9))
            0:       return 1;
            1:       return 2;
            2:       return 255;
            3:       return 256;
            4:       return 257;
            5:       return 511;
            6:       return 0;
            default: return $urandom_range(3, 256);
        endcase
    endfunction

    // mostly a valid position in the list, sometimes just past it or anywhere
    function automatic int pick_pos(input int cat);
        int cnt;
        cnt = loaded_per_cat[cat];
        if (cnt > 0 && $urandom_range(9) < 8)
            return $urandom_range(0, cnt - 1);
        else if ($urandom_range(1) == 0)
            return cnt;
        else
            return $urandom_range(0, MAX_W - 1);
    endfunction

    // one load / build / read sequence with a little noise
    task automatic run_episode();
        int n_words;
        int cat_lo;
        int span;
        int cat;
        if (loaded_total > 300 || $urandom_range(2) == 0)
            send(REQ_CLEAR, $urandom_range(255), $urandom_range(MAX_W - 1));
        n_words = $urandom_range(1, 40);
        case ($urandom_range(3))
            0:       span = 1;
            1:       span = 3;
            2:       span = 16;
            default: span = 256;
        endcase
        cat_lo = $urandom_range(255);
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(9) == 0)
                cat = $urandom_range(255);
            else
                cat = (cat_lo + $urandom_range(0, span - 1)) % MAX_C;
            send(REQ_LOAD, cat, $urandom_range(MAX_W - 1));
        end
        // now and then the sender waits for every result before the build
        if ($urandom_range(5) == 0)
            drain();
        send(REQ_BUILD, $urandom_range(255), $urandom_range(MAX_W - 1));
        for (int i = $urandom_range(5, 40); i > 0; i--) begin
            if ($urandom_range(19) < 17)
                cat = (cat_lo + $urandom_range(0, span - 1)) % MAX_C;
            else
                cat = $urandom_range(255);
            send(REQ_READ, cat, pick_pos(cat));
        end
        for (int i = $urandom_range(0, 4); i > 0; i--)
            send(REQ_W'($urandom_range(3)), $urandom_range(255), $urandom_range(MAX_W - 1));
    endtask

    function automatic int items_sent();
        return sent_by_req[0] + sent_by_req[1] + sent_by_req[2] + sent_by_req[3];
    endfunction

    initial begin : stimulus
        int mark;
        int cat;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        hold_reqs      = 0;
        send_idle_pct  = 34;
        recv_stall_pct = 71;
        cfg_now        = CFG_RESET;
        loaded_total   = 0;
        cfg_writes     = 0;
        foreach (loaded_per_cat[c])
            loaded_per_cat[c] = 0;
        foreach (sent_by_req[r])
            sent_by_req[r] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty build, ordering within lists, stale grouping, limits
        write_cfg(CFG_RESET);
        send(REQ_READ, 0, 0);
        send(REQ_BUILD, 0, 0);
        send(REQ_READ, 255, 4095);
        send(REQ_LOAD, 0, 4095);
        send(REQ_LOAD, 255, 0);
        send(REQ_LOAD, 7, 0);
        send(REQ_LOAD, 0, 0);
        send(REQ_READ, 0, 0);
        send(REQ_BUILD, 255, 4095);
        send(REQ_READ, 0, 0);
        send(REQ_READ, 0, 1);
        send(REQ_READ, 0, 2);
        send(REQ_READ, 255, 0);
        send(REQ_READ, 7, 0);
        send(REQ_CLEAR, 0, 0);
        send(REQ_READ, 7, 0);
        write_cfg(1);
        send(REQ_LOAD, 1, 0);
        send(REQ_LOAD, 0, 0);
        send(REQ_BUILD, 0, 0);
        send(REQ_READ, 0, 0);
        send(REQ_READ, 1, 0);
        write_cfg(0);
        send(REQ_LOAD, 0, 0);
        send(REQ_READ, 0, 0);
        // a register write keeps the grouping
        write_cfg(8);
        send(REQ_READ, 0, 0);
        write_cfg(511);
        send(REQ_READ, 255, 0);
        send(REQ_CLEAR, 255, 4095);

        // random episodes under three idling mixes
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct  = (mode == 0) ? 34 : (mode == 1) ? 71 : 0;
            recv_stall_pct = (mode == 0) ? 71 : (mode == 1) ? 34 : 0;
            write_cfg(mode == 2 ? 256 : pick_cfg());
            mark = items_sent();
            while (items_sent() - mark < RAND_ITEMS) begin
                if ($urandom_range(5) == 0)
                    write_cfg(pick_cfg());
                run_episode();
            end
        end

        // long receiver hold-off while loads keep coming
        write_cfg(256);
        send(REQ_CLEAR, 0, 0);
        hold_reqs++;
        for (int i = 0; i < 40; i++)
            send(REQ_LOAD, $urandom_range(255), $urandom_range(MAX_W - 1));
        send(REQ_BUILD, 0, 0);
        for (int i = 0; i < 20; i++) begin
            cat = $urandom_range(255);
            send(REQ_READ, cat, pick_pos(cat));
        end
        send(REQ_CLEAR, 0, 0);

        // wait out the last results
        i_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d loads, %0d builds, %0d reads, %0d clears, %0d register writes",
                 sent_by_req[REQ_LOAD], sent_by_req[REQ_BUILD], sent_by_req[REQ_READ],
                 sent_by_req[REQ_CLEAR], cfg_writes);
        $display("%0d results compared, including a %0d-cycle receiver hold-off with input stalled",
                 checked, HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: category_word_grouper.f
rtl/core/cwg_pkg.sv
rtl/core/cwg_alu.sv
rtl/core/cwg_ctrl.sv
rtl/core/category_word_grouper.sv
rtl/core/cwg_checker.sv
tb/cwg_checker.sv
tb/tb_category_word_grouper.sv
